### hw/rtl/tbpe_pkg.sv
// ----------------------------------------------------------------------------
// tbpe_pkg: shared types and constants of the tape block pulse encoder
// Segment kinds, parser states, queued commands and register defaults.
// ----------------------------------------------------------------------------
package tbpe_pkg;

  localparam int unsigned RegW  = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegPilotHp   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPilotCnt  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSync1Hp   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSync2Hp   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegZeroHp    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegOneHp     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPauseLen  = 3'd6;

  // Register reset values.
  localparam logic [RegW-1:0] PilotHpRst  = 16'd25;
  localparam logic [RegW-1:0] PilotCntRst = 16'd7056;
  localparam logic [RegW-1:0] Sync1HpRst  = 16'd7;
  localparam logic [RegW-1:0] Sync2HpRst  = 16'd8;
  localparam logic [RegW-1:0] ZeroHpRst   = 16'd9;
  localparam logic [RegW-1:0] OneHpRst    = 16'd19;
  localparam logic [RegW-1:0] PauseLenRst = 16'd44100;

  // Half-period counts of the fixed-length segments.
  localparam logic [RegW-1:0] SyncCount = 16'd1;
  localparam logic [RegW-1:0] BitCount  = 16'd2;
  localparam logic [RegW-1:0] PauseCount = 16'd1;

  // Step counter of the segment sequencer: up to nine segments per command.
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] StepSync2    = 4'd2;
  localparam logic [StepW-1:0] StepHdrPause = 4'd3;
  localparam logic [StepW-1:0] StepLastBit  = 4'd7;

  typedef enum logic [2:0] {
    SEG_PILOT = 3'd0,
    SEG_SYNC1 = 3'd1,
    SEG_SYNC2 = 3'd2,
    SEG_ZERO  = 3'd3,
    SEG_ONE   = 3'd4,
    SEG_PAUSE = 3'd5
  } seg_kind_e;

  typedef enum logic [1:0] {
    PH_LEN_LO = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_DATA   = 2'd2
  } parse_phase_e;

  typedef enum logic [1:0] {
    CMD_HDR       = 2'd0,  // pilot and syncs, data follows
    CMD_HDR_EMPTY = 2'd1,  // pilot, syncs and pause of a zero-length block
    CMD_DATA      = 2'd2,  // eight bit segments
    CMD_DATA_LAST = 2'd3   // eight bit segments and the closing pause
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [ByteW-1:0]   data;
  } cmd_t;

  typedef struct packed {
    logic [RegW-1:0] pilot_hp;
    logic [RegW-1:0] pilot_cnt;
    logic [RegW-1:0] sync1_hp;
    logic [RegW-1:0] sync2_hp;
    logic [RegW-1:0] zero_hp;
    logic [RegW-1:0] one_hp;
    logic [RegW-1:0] pause_len;
  } cfg_t;

endpackage

### hw/rtl/tbpe_front.sv
// ----------------------------------------------------------------------------
// tbpe_front: tape image parser
// Tracks the block header and data count and turns each high length byte and data byte into a command.
// ----------------------------------------------------------------------------
module tbpe_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [tbpe_pkg::ByteW-1:0] tap_byte_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      q_full_i,
  output logic                      push_o,
  output tbpe_pkg::cmd_t            cmd_o
);

  tbpe_pkg::parse_phase_e phase_q, phase_d;
  logic [tbpe_pkg::ByteW-1:0] len_lo_q, len_lo_d;
  logic [tbpe_pkg::RegW-1:0]  remain_q, remain_d;
  logic                       accept;
  logic [tbpe_pkg::RegW-1:0]  len;
  logic                       len_zero;
  logic                       last_byte;

  assign len       = {tap_byte_i, len_lo_q};
  assign len_zero  = (len == '0);
  assign last_byte = (remain_q == tbpe_pkg::RegW'(1));

  // A low length byte produces no command, so it never waits for the queue.
  assign in_ready_o = (phase_q == tbpe_pkg::PH_LEN_LO) || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    len_lo_d = len_lo_q;
    remain_d = remain_q;
    if (accept) begin
      unique case (phase_q)
        tbpe_pkg::PH_LEN_HI: begin
          remain_d = len;
          phase_d  = len_zero ? tbpe_pkg::PH_LEN_LO : tbpe_pkg::PH_DATA;
        end
        tbpe_pkg::PH_DATA: begin
          remain_d = remain_q - tbpe_pkg::RegW'(1);
          phase_d  = last_byte ? tbpe_pkg::PH_LEN_LO : tbpe_pkg::PH_DATA;
        end
        default: begin
          len_lo_d = tap_byte_i;
          phase_d  = tbpe_pkg::PH_LEN_HI;
        end
      endcase
    end
  end

  always_comb begin
    push_o     = 1'b0;
    cmd_o.data = tap_byte_i;
    cmd_o.kind = tbpe_pkg::CMD_HDR;
    unique case (phase_q)
      tbpe_pkg::PH_LEN_HI: begin
        push_o     = accept;
        cmd_o.kind = len_zero ? tbpe_pkg::CMD_HDR_EMPTY : tbpe_pkg::CMD_HDR;
      end
      tbpe_pkg::PH_DATA: begin
        push_o     = accept;
        cmd_o.kind = last_byte ? tbpe_pkg::CMD_DATA_LAST : tbpe_pkg::CMD_DATA;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= tbpe_pkg::PH_LEN_LO;
      len_lo_q <= '0;
      remain_q <= '0;
    end else begin
      phase_q  <= phase_d;
      len_lo_q <= len_lo_d;
      remain_q <= remain_d;
    end
  end

endmodule

### hw/rtl/tbpe_queue.sv
// ----------------------------------------------------------------------------
// tbpe_queue: two-entry command queue
// Decouples the parser from the segment sequencer.
// ----------------------------------------------------------------------------
module tbpe_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbpe_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tbpe_pkg::cmd_t cmd_o
);

  tbpe_pkg::cmd_t entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

### hw/rtl/tbpe_back.sv
// ----------------------------------------------------------------------------
// tbpe_back: segment sequencer
// Expands the command at the queue head into segments, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module tbpe_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tbpe_pkg::cfg_t            cfg_i,
  input  logic                      cmd_valid_i,
  input  tbpe_pkg::cmd_t            cmd_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                segment_kind_o,
  output logic                      start_level_o,
  output logic [tbpe_pkg::RegW-1:0] half_period_o,
  output logic [tbpe_pkg::RegW-1:0] half_count_o,
  output logic                      last_of_run_o
);

  logic [tbpe_pkg::StepW-1:0] step_q, step_d;
  logic                       level_q, level_d;
  logic                       out_valid_q;
  tbpe_pkg::seg_kind_e        kind_q, seg_kind;
  logic                       start_q, last_q;
  logic [tbpe_pkg::RegW-1:0]  hp_q, cnt_q, seg_hp, seg_cnt;
  logic                       seg_last;
  logic                       fire;
  logic                       bit_val;

  assign fire    = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign bit_val = cmd_i.data[3'(tbpe_pkg::StepLastBit - step_q)];

  always_comb begin
    seg_kind = tbpe_pkg::SEG_PAUSE;
    seg_hp   = cfg_i.pause_len;
    seg_cnt  = tbpe_pkg::PauseCount;
    seg_last = 1'b1;
    unique case (cmd_i.kind)
      tbpe_pkg::CMD_HDR, tbpe_pkg::CMD_HDR_EMPTY: begin
        seg_last = (cmd_i.kind == tbpe_pkg::CMD_HDR) ? (step_q == tbpe_pkg::StepSync2)
                                                     : (step_q == tbpe_pkg::StepHdrPause);
        priority case (step_q)
          tbpe_pkg::StepW'(0): begin
            seg_kind = tbpe_pkg::SEG_PILOT;
            seg_hp   = cfg_i.pilot_hp;
            seg_cnt  = cfg_i.pilot_cnt;
          end
          tbpe_pkg::StepW'(1): begin
            seg_kind = tbpe_pkg::SEG_SYNC1;
            seg_hp   = cfg_i.sync1_hp;
            seg_cnt  = tbpe_pkg::SyncCount;
          end
          tbpe_pkg::StepSync2: begin
            seg_kind = tbpe_pkg::SEG_SYNC2;
            seg_hp   = cfg_i.sync2_hp;
            seg_cnt  = tbpe_pkg::SyncCount;
          end
          default: begin
            seg_kind = tbpe_pkg::SEG_PAUSE;
          end
        endcase
      end
      default: begin
        seg_last = (cmd_i.kind == tbpe_pkg::CMD_DATA) ? (step_q == tbpe_pkg::StepLastBit)
                                                      : (step_q > tbpe_pkg::StepLastBit);
        if (step_q <= tbpe_pkg::StepLastBit) begin
          seg_kind = bit_val ? tbpe_pkg::SEG_ONE : tbpe_pkg::SEG_ZERO;
          seg_hp   = bit_val ? cfg_i.one_hp : cfg_i.zero_hp;
          seg_cnt  = tbpe_pkg::BitCount;
        end
      end
    endcase
  end

  // The level flips once per half-period, so only the count's parity matters.
  always_comb begin
    step_d  = step_q;
    level_d = level_q;
    if (fire) begin
      level_d = level_q ^ seg_cnt[0];
      step_d  = seg_last ? '0 : step_q + tbpe_pkg::StepW'(1);
    end
  end

  assign pop_o = fire && seg_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      level_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      level_q <= level_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q  <= seg_kind;
      start_q <= level_q;
      hp_q    <= seg_hp;
      cnt_q   <= seg_cnt;
      last_q  <= seg_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign segment_kind_o = kind_q;
  assign start_level_o  = start_q;
  assign half_period_o  = hp_q;
  assign half_count_o   = cnt_q;
  assign last_of_run_o  = last_q;

endmodule

### hw/rtl/tape_block_pulse_encoder.sv
// ----------------------------------------------------------------------------
// tape_block_pulse_encoder: tape image to square-wave segment encoder
// Parses length-prefixed tape blocks and describes the tape signal as
// segments of pilot, sync, bit and pause tones.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake             | Word
// input    | in        | in_valid_i/in_ready_o | tap_byte_i
// output   | out       | out_valid_o/out_ready_i | segment_kind_o .. last_of_run_o
// config   | in        | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// The sequencer gives one segment per cycle unless the output stalls: a data
// byte gives eight segments, nine for the last byte of a block, a header gives
// three or four, and a low length byte gives none and is taken by the parser
// only. A two-word queue lets the parser take bytes while segments are still
// going out. Reset restores the register defaults and the parser start.
// ----------------------------------------------------------------------------
module tape_block_pulse_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tbpe_pkg::ByteW-1:0]   tap_byte_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  output logic [2:0]                   segment_kind_o,
  output logic                         start_level_o,
  output logic [tbpe_pkg::RegW-1:0]    half_period_o,
  output logic [tbpe_pkg::RegW-1:0]    half_count_o,
  output logic                         last_of_run_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  input  logic                         cfg_we_i,
  input  logic [tbpe_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tbpe_pkg::RegW-1:0]    cfg_data_i
);

  tbpe_pkg::cfg_t cfg_q;
  tbpe_pkg::cmd_t push_cmd, head_cmd;
  logic           push, pop, q_full, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pilot_hp  <= tbpe_pkg::PilotHpRst;
      cfg_q.pilot_cnt <= tbpe_pkg::PilotCntRst;
      cfg_q.sync1_hp  <= tbpe_pkg::Sync1HpRst;
      cfg_q.sync2_hp  <= tbpe_pkg::Sync2HpRst;
      cfg_q.zero_hp   <= tbpe_pkg::ZeroHpRst;
      cfg_q.one_hp    <= tbpe_pkg::OneHpRst;
      cfg_q.pause_len <= tbpe_pkg::PauseLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbpe_pkg::RegPilotHp:  cfg_q.pilot_hp  <= cfg_data_i;
        tbpe_pkg::RegPilotCnt: cfg_q.pilot_cnt <= cfg_data_i;
        tbpe_pkg::RegSync1Hp:  cfg_q.sync1_hp  <= cfg_data_i;
        tbpe_pkg::RegSync2Hp:  cfg_q.sync2_hp  <= cfg_data_i;
        tbpe_pkg::RegZeroHp:   cfg_q.zero_hp   <= cfg_data_i;
        tbpe_pkg::RegOneHp:    cfg_q.one_hp    <= cfg_data_i;
        tbpe_pkg::RegPauseLen: cfg_q.pause_len <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  tbpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tap_byte_i (tap_byte_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tbpe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  tbpe_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_valid_i    (q_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .segment_kind_o (segment_kind_o),
    .start_level_o  (start_level_o),
    .half_period_o  (half_period_o),
    .half_count_o   (half_count_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule
